FILE: design/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
	localparam int W = 32;
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [W-1:0] a_num;
		logic signed [W-1:0] a_den;
		logic signed [W-1:0] b_num;
		logic signed [W-1:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [W-1:0] res_num;
		logic [W-2:0] res_den;
		logic [1:0] status;
	} out_word_t;
endpackage

FILE: design/rau_divider.sv
// rau_divider: shared 64-bit restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_divider import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [63:0] divisor,
	output logic done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	logic [6:0] cnt_q;
	logic busy_q;
	logic [63:0] q_q, r_q, d_q;
	logic [64:0] trial;
	logic [64:0] sh;

	assign sh = {r_q, q_q[63]};
	assign trial = sh - {1'b0, d_q};
	assign quot = q_q;
	assign rem = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= sh[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

FILE: design/rational_arith_unit.sv
// rational_arith_unit: top level, sequencer around the shared divider.
// Depends on rau_pkg and rau_divider.
//
// channel | direction | signals
// in      | into      | in_valid, in_stall, in_data (in_word_t)
// out     | out of    | out_valid, out_stall, out_data (out_word_t)
//
// A word with a zero denominator ends after the check. Each Euclid step
// issues one division on the shared divider; the operand denominator GCD
// (add/sub only) takes up to 46 steps and the result GCD up to about 91.
// in_stall is high from acceptance until the result word leaves the output
// register. Reset clears the sequencer and the output valid.
module rational_arith_unit import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_word_t out_data
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK = 4'd1;
	localparam logic [3:0] S_G1 = 4'd2;
	localparam logic [3:0] S_G1W = 4'd3;
	localparam logic [3:0] S_DA = 4'd4;
	localparam logic [3:0] S_DAW = 4'd5;
	localparam logic [3:0] S_DB = 4'd6;
	localparam logic [3:0] S_DBW = 4'd7;
	localparam logic [3:0] S_M1 = 4'd8;
	localparam logic [3:0] S_M2 = 4'd9;
	localparam logic [3:0] S_G2 = 4'd10;
	localparam logic [3:0] S_G2W = 4'd11;
	localparam logic [3:0] S_RN = 4'd12;
	localparam logic [3:0] S_RNW = 4'd13;
	localparam logic [3:0] S_RDW = 4'd14;
	localparam logic [3:0] S_FIN = 4'd15;

	logic [3:0] st_q;
	logic [1:0] mode_q;
	logic [31:0] ma_q, da_q, mb_q, db_q;
	logic sa_q, sb_q, neg_q;
	logic [63:0] x_q, y_q, g_q, num_q, den_q, t1_q, t2_q;
	logic bad_q;

	logic dv_start, dv_done;
	logic [63:0] dv_a, dv_b, dv_q, dv_r;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.dividend(dv_a), .divisor(dv_b), .done(dv_done),
		.quot(dv_q), .rem(dv_r)
	);

	function automatic logic [31:0] mag(input logic [31:0] v);
		mag = v[31] ? (~v + 32'd1) : v;
	endfunction

	logic [31:0] m0, m1, m2, m3;
	logic [63:0] prod;
	assign m0 = mag(in_data.a_num);
	assign m1 = mag(in_data.a_den);
	assign m2 = mag(in_data.b_num);
	assign m3 = mag(in_data.b_den);

	always_comb begin
		dv_start = 1'b0;
		dv_a = x_q;
		dv_b = y_q;
		case (st_q)
			S_G1, S_G2: dv_start = (y_q != 64'd0);
			S_DA: begin
				dv_start = 1'b1; dv_a = {32'd0, da_q}; dv_b = g_q;
			end
			S_DB: begin
				dv_start = 1'b1; dv_a = {32'd0, db_q}; dv_b = g_q;
			end
			S_RN: begin
				dv_start = 1'b1; dv_a = num_q; dv_b = g_q;
			end
			S_RNW: begin
				dv_start = dv_done; dv_a = den_q; dv_b = g_q;
			end
			default: ;
		endcase
	end

	assign in_stall = (st_q != S_IDLE) || out_valid;

	logic [63:0] gfin;
	assign gfin = (x_q == 64'd0) ? 64'd1 : x_q;
	logic [63:0] maxp;
	assign maxp = 64'h7FFF_FFFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) st_q <= S_CHK;
				S_CHK: begin
					if (bad_q) begin
						out_data <= '{res_num: '0, res_den: '0, status: ST_ZERO};
						out_valid <= 1'b1;
						st_q <= S_IDLE;
					end else if (mode_q[1]) begin
						st_q <= S_M1;
					end else st_q <= S_G1;
				end
				S_G1: if (y_q == 64'd0) begin
					g_q <= gfin; st_q <= S_DA;
				end else st_q <= S_G1W;
				S_G1W: if (dv_done) st_q <= S_G1;
				S_DA: st_q <= S_DAW;
				S_DAW: if (dv_done) st_q <= S_DB;
				S_DB: st_q <= S_DBW;
				S_DBW: if (dv_done) st_q <= S_M1;
				S_M1: st_q <= S_M2;
				S_M2: begin
					if (t1_q == 64'd0) begin
						out_data <= '{res_num: '0, res_den: 31'd1, status: ST_OK};
						out_valid <= 1'b1;
						st_q <= S_IDLE;
					end else st_q <= S_G2;
				end
				S_G2: if (y_q == 64'd0) begin
					g_q <= gfin; st_q <= S_RN;
				end else st_q <= S_G2W;
				S_G2W: if (dv_done) st_q <= S_G2;
				S_RN: st_q <= S_RNW;
				S_RNW: if (dv_done) st_q <= S_RDW;
				S_RDW: if (dv_done) st_q <= S_FIN;
				S_FIN: begin
					if (den_q > maxp || num_q > maxp + {63'd0, neg_q})
						out_data <= '{res_num: '0, res_den: '0, status: ST_OVF};
					else
						out_data <= '{res_num: neg_q ? (~num_q[31:0] + 32'd1) : num_q[31:0],
							res_den: den_q[30:0], status: ST_OK};
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		case (mode_q)
			MODE_MUL: prod = {32'd0, ma_q} * {32'd0, mb_q};
			MODE_DIV: prod = {32'd0, ma_q} * {32'd0, db_q};
			default: prod = t1_q;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				mode_q <= in_data.mode;
				ma_q <= m0; da_q <= m1; mb_q <= m2; db_q <= m3;
				sa_q <= (in_data.a_num[31] != in_data.a_den[31]) && m0 != 32'd0;
				sb_q <= (in_data.b_num[31] != in_data.b_den[31]) && m2 != 32'd0;
				bad_q <= m1 == 32'd0 || m3 == 32'd0
					|| (in_data.mode == MODE_DIV && m2 == 32'd0);
				x_q <= {32'd0, m1};
				y_q <= {32'd0, m3};
			end
			S_CHK: if (mode_q == MODE_SUB) sb_q <= !sb_q && mb_q != 32'd0;
			S_G1W, S_G2W: if (dv_done) begin
				x_q <= y_q; y_q <= dv_r;
			end
			S_DAW: if (dv_done) begin
				t2_q <= {32'd0, mb_q} * {32'd0, dv_q[31:0]};
				den_q <= {32'd0, dv_q[31:0]} * {32'd0, db_q};
			end
			S_DBW: if (dv_done) t1_q <= {32'd0, ma_q} * {32'd0, dv_q[31:0]};
			S_M1: begin
				if (mode_q[1]) begin
					t1_q <= prod;
					den_q <= (mode_q == MODE_MUL) ? {32'd0, da_q} * {32'd0, db_q}
						: {32'd0, da_q} * {32'd0, mb_q};
					neg_q <= sa_q != sb_q;
				end else if (sa_q == sb_q) begin
					t1_q <= t1_q + t2_q; neg_q <= sa_q;
				end else if (t1_q >= t2_q) begin
					t1_q <= t1_q - t2_q; neg_q <= sa_q;
				end else begin
					t1_q <= t2_q - t1_q; neg_q <= sb_q;
				end
			end
			S_M2: begin
				num_q <= t1_q; x_q <= t1_q; y_q <= den_q;
			end
			S_RNW: if (dv_done) num_q <= dv_q;
			S_RDW: if (dv_done) den_q <= dv_q;
			default: ;
		endcase
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> in_stall) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result lost");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> (out_data.res_den == '0))
		else $error("error with nonzero den");
endmodule

FILE: verif/rau_checker.sv
// rau_checker: watches both channels of rational_arith_unit, predicts each
// reduced fraction and compares it with the word that leaves the block.
// Depends on rau_pkg.
module rau_checker import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_word_t in_data,
	input logic out_valid,
	input logic out_stall,
	input out_word_t out_data,
	output int errors,
	output int pending
);
	out_word_t fractions_due[$];

	function automatic longint unsigned magnitude(logic [31:0] v);
		logic [31:0] m;
		m = v[31] ? (~v + 32'd1) : v;
		return {32'd0, m};
	endfunction

	function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return (x == 0) ? 64'd1 : x;
	endfunction

	function automatic out_word_t reduce_fraction(in_word_t w);
		out_word_t r;
		longint unsigned ma, da, mb, db, num, den, g, t1, t2, maxpos;
		logic sa, sb, neg;
		r = '0;
		ma = magnitude(w.a_num);
		da = magnitude(w.a_den);
		mb = magnitude(w.b_num);
		db = magnitude(w.b_den);
		if (da == 0 || db == 0 || (w.mode == MODE_DIV && mb == 0)) begin
			r.status = ST_ZERO;
			return r;
		end
		sa = (w.a_num[31] != w.a_den[31]) && ma != 0;
		sb = (w.b_num[31] != w.b_den[31]) && mb != 0;
		if (w.mode == MODE_ADD || w.mode == MODE_SUB) begin
			if (w.mode == MODE_SUB)
				sb = !sb && mb != 0;
			g = euclid(da, db);
			den = (da / g) * db;
			t1 = ma * (db / g);
			t2 = mb * (da / g);
			if (sa == sb) begin
				num = t1 + t2;
				neg = sa;
			end else if (t1 >= t2) begin
				num = t1 - t2;
				neg = sa;
			end else begin
				num = t2 - t1;
				neg = sb;
			end
		end else if (w.mode == MODE_MUL) begin
			num = ma * mb;
			den = da * db;
			neg = sa != sb;
		end else begin
			num = ma * db;
			den = da * mb;
			neg = sa != sb;
		end
		if (num == 0) begin
			r.res_den = 31'd1;
			r.status = ST_OK;
			return r;
		end
		g = euclid(num, den);
		num = num / g;
		den = den / g;
		maxpos = 64'h7FFF_FFFF;
		if (den > maxpos || num > maxpos + (neg ? 64'd1 : 64'd0)) begin
			r.status = ST_OVF;
			return r;
		end
		r.res_num = neg ? (~num[31:0] + 32'd1) : num[31:0];
		r.res_den = den[30:0];
		r.status = ST_OK;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial errors = 0;
	assign pending = fractions_due.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			fractions_due.delete();
		end else begin
			if (in_valid && !in_stall)
				fractions_due.push_back(reduce_fraction(in_data));
			if (out_valid && !out_stall) begin
				if (fractions_due.size() == 0) begin
					report("unexpected word, status", out_data.status, -1);
				end else begin
					want = fractions_due.pop_front();
					if (out_data.res_num !== want.res_num)
						report("res_num", out_data.res_num, want.res_num);
					if (out_data.res_den !== want.res_den)
						report("res_den", out_data.res_den, want.res_den);
					if (out_data.status !== want.status)
						report("status", out_data.status, want.status);
				end
			end
		end
	end
endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for rational_arith_unit; directed fractions,
// then random ones with random gaps and stalls. Depends on rau_pkg,
// rational_arith_unit and rau_checker.
module tb;
	import rau_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1;
	out_word_t out_data;
	int errors;
	int pending;

	always #2 clk = ~clk;

	rational_arith_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	rau_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	function automatic logic [31:0] pick_field(bit is_den);
		case ($urandom_range(0, 11))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return is_den ? ($urandom_range(0, 30) == 0 ? 32'd0 : 32'd1) : 32'd0;
			4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
			5: return 32'($signed($urandom_range(0, 131070)) - 65535);
			default: return 32'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	task automatic send_word(in_word_t w, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_fraction(logic [1:0] m, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		in_word_t w;
		w.mode = m;
		w.a_num = an;
		w.a_den = ad;
		w.b_num = bn;
		w.b_den = bd;
		send_word(w, $urandom_range(0, 5));
	endtask

	// receiver: random stalls, one long hold-off early on
	initial begin
		int n;
		n = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (n == 30) begin
				out_stall <= 1;
				repeat (20000) @(negedge clk);
			end else if ((n / 150) % 3 == 1) begin
				out_stall <= 1;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			n++;
		end
	end

	initial begin
		in_word_t w;
		logic [1:0] m;
		@(negedge clk);
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int k = 0; k < 4; k++) begin
			m = k[1:0];
			send_fraction(m, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
			send_fraction(m, 32'd3, 32'hFFFF_FFFC, 32'h8000_0000, 32'h8000_0000);
			send_fraction(m, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd2, 32'h8000_0000);
		end
		send_fraction(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
		send_fraction(MODE_MUL, 32'd1, 32'd2, 32'd1, 32'd0);
		send_fraction(MODE_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
		send_fraction(MODE_SUB, 32'd1, 32'd2, 32'd2, 32'd4);
		send_fraction(MODE_ADD, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd3);
		send_fraction(MODE_MUL, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
		send_fraction(MODE_DIV, 32'd1, 32'h7FFF_FFFF, 32'd3, 32'd1);
		send_fraction(MODE_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
		send_fraction(MODE_ADD, 32'd6, 32'hFFFF_FFF8, 32'hFFFF_FFFA, 32'd8);
		while (pending != 0) @(negedge clk);
		for (int i = 0; i < 1730; i++) begin
			if (i == 900)
				while (pending != 0) @(negedge clk);
			w.mode = $urandom_range(0, 3);
			w.a_num = pick_field(0);
			w.a_den = pick_field(1);
			w.b_num = pick_field(0);
			w.b_den = pick_field(1);
			send_word(w, ((i / 200) % 3 == 0) ? 0 : $urandom_range(0, 5));
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#300000000;
		$display("tb: FAIL");
		$finish;
	end
endmodule
